### hdl/mtm_pkg.sv
`default_nettype none
// ---------------------------------------------------------------------------
// Model transform matrix package
// Shared types, constants and fixed-point helpers for the matrix unit.
// ---------------------------------------------------------------------------
package mtm_pkg;

	// Depth of the queue between the CORDIC front and the matrix back.
	localparam int QDEPTH = 16;
	localparam int QAW    = $clog2(QDEPTH);

	// Angles in 1/64 degree.
	localparam logic [16:0] DEG_UNITS    = 17'd23040;
	localparam logic [16:0] HALF_TURN_U  = 17'd11520;
	localparam logic signed [15:0] HALF_TURN    = 16'sd11520;
	localparam logic signed [15:0] QUARTER_TURN = 16'sd5760;
	localparam logic signed [15:0] FULL_TURN    = 16'sd23040;
	localparam logic signed [16:0] ANGLE_BIAS   = 17'sd46080;

	// CORDIC working width and start gain in Q30.
	localparam int XW = 34;
	localparam logic signed [XW-1:0] GAIN_Q30 = 34'sd652032874;

	// atan(2^-i) in degrees with 22 fraction bits.
	localparam logic signed [31:0] ATAN_TAB [0:30] = '{
		32'sd188743680, 32'sd111421900, 32'sd58872272, 32'sd29884485,
		32'sd15000234, 32'sd7507429, 32'sd3754631, 32'sd1877430,
		32'sd938729, 32'sd469366, 32'sd234683, 32'sd117342,
		32'sd58671, 32'sd29335, 32'sd14668, 32'sd7334,
		32'sd3667, 32'sd1833, 32'sd917, 32'sd458,
		32'sd229, 32'sd115, 32'sd57, 32'sd29,
		32'sd14, 32'sd7, 32'sd4, 32'sd2,
		32'sd1, 32'sd0, 32'sd0
	};

	// One transform after the trigonometry, as held in the queue.
	typedef struct packed {
		logic signed [31:0] tx;
		logic signed [31:0] ty;
		logic signed [31:0] tz;
		logic signed [31:0] scale;
		logic signed [31:0] sa;
		logic signed [31:0] ca;
		logic signed [31:0] sb;
		logic signed [31:0] cb;
		logic signed [31:0] sc;
		logic signed [31:0] cc;
	} entry_t;

	// Handshake between the queue and the back end.
	typedef struct packed {
		logic valid;
		entry_t data;
	} head_t;

	// Product of two Q30 values, rounded back to Q30.
	function automatic logic signed [31:0] mul30(input logic signed [31:0] a,
		input logic signed [31:0] b);
		logic signed [63:0] p;
		p = a * b + 64'sd536870912;
		return 32'(p >>> 30);
	endfunction

endpackage

`default_nettype wire

### hdl/mtm_front.sv
`default_nettype none
// ---------------------------------------------------------------------------
// Matrix unit front end
// Reduces the three angles and runs them through a pipelined CORDIC.
// ---------------------------------------------------------------------------
module mtm_front #(
	parameter int CORDIC_STEPS = 16
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            in_valid,
	input  wire logic [31:0]     trans_x,
	input  wire logic [31:0]     trans_y,
	input  wire logic [31:0]     trans_z,
	input  wire logic [15:0]     angle_x,
	input  wire logic [15:0]     angle_y,
	input  wire logic [15:0]     angle_z,
	input  wire logic [31:0]     uniform_scale,
	output logic                 push,
	output mtm_pkg::entry_t      push_data
);
	import mtm_pkg::*;

	localparam int N = CORDIC_STEPS;

	typedef struct packed {
		logic signed [31:0] tx;
		logic signed [31:0] ty;
		logic signed [31:0] tz;
		logic signed [31:0] scale;
	} pay_t;

	typedef struct packed {
		logic neg;
		logic signed [31:0] z;
	} red_t;

	// Angle to the range of plus or minus a quarter turn, with a negate flag.
	function automatic red_t reduce(input logic [15:0] a);
		logic [16:0] u;
		logic signed [15:0] r;
		red_t o;
		u = 17'($signed({a[15], a}) + ANGLE_BIAS);
		for (int k = 0; k < 3; k++) begin
			if (u >= DEG_UNITS)
				u = u - DEG_UNITS;
		end
		r = 16'(u);
		if (u >= HALF_TURN_U)
			r = r - FULL_TURN;
		o.neg = 1'b0;
		if (r > QUARTER_TURN) begin
			r = r - HALF_TURN;
			o.neg = 1'b1;
		end else if (r < -QUARTER_TURN) begin
			r = r + HALF_TURN;
			o.neg = 1'b1;
		end
		o.z = {r, 16'd0};
		return o;
	endfunction

	logic                  v_q   [0:N];
	pay_t                  pay_q [0:N];
	logic                  neg_q [0:N][0:2];
	logic signed [XW-1:0]  x_q   [0:N][0:2];
	logic signed [XW-1:0]  y_q   [0:N][0:2];
	logic signed [31:0]    z_q   [0:N][0:2];

	red_t red [0:2];

	always_comb begin
		red[0] = reduce(angle_x);
		red[1] = reduce(angle_y);
		red[2] = reduce(angle_z);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_q[0] <= 1'b0;
		else
			v_q[0] <= in_valid;
	end

	always_ff @(posedge clk) begin
		pay_q[0] <= '{tx: trans_x, ty: trans_y, tz: trans_z, scale: uniform_scale};
		for (int l = 0; l < 3; l++) begin
			neg_q[0][l] <= red[l].neg;
			x_q[0][l]   <= GAIN_Q30;
			y_q[0][l]   <= '0;
			z_q[0][l]   <= red[l].z;
		end
	end

	for (genvar i = 0; i < N; i++) begin : g_step
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				v_q[i+1] <= 1'b0;
			else
				v_q[i+1] <= v_q[i];
		end

		always_ff @(posedge clk) begin
			pay_q[i+1] <= pay_q[i];
			for (int l = 0; l < 3; l++) begin
				neg_q[i+1][l] <= neg_q[i][l];
				if (!z_q[i][l][31]) begin
					x_q[i+1][l] <= x_q[i][l] - (y_q[i][l] >>> i);
					y_q[i+1][l] <= y_q[i][l] + (x_q[i][l] >>> i);
					z_q[i+1][l] <= z_q[i][l] - ATAN_TAB[i];
				end else begin
					x_q[i+1][l] <= x_q[i][l] + (y_q[i][l] >>> i);
					y_q[i+1][l] <= y_q[i][l] - (x_q[i][l] >>> i);
					z_q[i+1][l] <= z_q[i][l] + ATAN_TAB[i];
				end
			end
		end
	end

	logic signed [31:0] sn [0:2];
	logic signed [31:0] cs [0:2];

	always_comb begin
		for (int l = 0; l < 3; l++) begin
			if (neg_q[N][l]) begin
				sn[l] = 32'(-y_q[N][l]);
				cs[l] = 32'(-x_q[N][l]);
			end else begin
				sn[l] = 32'(y_q[N][l]);
				cs[l] = 32'(x_q[N][l]);
			end
		end
	end

	assign push = v_q[N];
	assign push_data = '{tx: pay_q[N].tx, ty: pay_q[N].ty, tz: pay_q[N].tz,
		scale: pay_q[N].scale, sa: sn[0], ca: cs[0], sb: sn[1], cb: cs[1],
		sc: sn[2], cc: cs[2]};

endmodule

`default_nettype wire

### hdl/mtm_queue.sv
`default_nettype none
// ---------------------------------------------------------------------------
// Matrix unit queue
// Small first-in first-out store between the front and back ends.
// ---------------------------------------------------------------------------
module mtm_queue (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        push,
	input  mtm_pkg::entry_t  push_data,
	input  wire logic        pop,
	output mtm_pkg::head_t   head
);
	import mtm_pkg::*;

	entry_t         mem_q [0:QDEPTH-1];
	logic [QAW-1:0] wr_q;
	logic [QAW-1:0] rd_q;
	logic [QAW:0]   cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push)
				wr_q <= wr_q + 1'b1;
			if (pop)
				rd_q <= rd_q + 1'b1;
			if (push && !pop)
				cnt_q <= cnt_q + 1'b1;
			else if (pop && !push)
				cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_q] <= push_data;
	end

	assign head.valid = (cnt_q != '0);
	assign head.data  = mem_q[rd_q];

endmodule

`default_nettype wire

### hdl/mtm_back.sv
`default_nettype none
// ---------------------------------------------------------------------------
// Matrix unit back end
// Forms the rotation product, scales it and sends the four rows.
// ---------------------------------------------------------------------------
module mtm_back #(
	parameter int FRAC_BITS = 16
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  mtm_pkg::head_t   head,
	output logic             pop,
	output logic             row_valid,
	output logic [1:0]       row_index,
	output logic [31:0]      elem_c0,
	output logic [31:0]      elem_c1,
	output logic [31:0]      elem_c2,
	output logic [31:0]      elem_c3,
	output logic             last_row
);
	import mtm_pkg::*;

	localparam logic [31:0] ONE = 32'(64'd1 << FRAC_BITS);
	localparam logic [1:0]  ROW_LAST = 2'd3;

	// First product stage.
	logic               v_s1;
	logic signed [31:0] cbcc_s1, cbsc_s1, sasb_s1, casc_s1, cacc_s1;
	logic signed [31:0] sacb_s1, casb_s1, sasc_s1, sacc_s1, cacb_s1;
	logic signed [31:0] sb_s1, sc_s1, cc_s1, tx_s1, ty_s1, tz_s1, scl_s1;

	// Second product stage.
	logic               v_s2;
	logic signed [31:0] cbcc_s2, cbsc_s2, casc_s2, cacc_s2;
	logic signed [31:0] sacb_s2, sasc_s2, sacc_s2, cacb_s2, sb_s2;
	logic signed [31:0] ssc_s2, sss_s2, csc_s2, css_s2;
	logic signed [31:0] tx_s2, ty_s2, tz_s2, scl_s2;

	// Held matrix, sent one row per cycle.
	logic               hold_q;
	logic [1:0]         row_q;
	logic signed [33:0] rm_q  [0:2][0:2];
	logic signed [31:0] tr_q  [0:2];
	logic signed [31:0] scl_q;

	logic hold_free, adv2, adv1;
	logic signed [33:0] rn [0:2][0:2];

	assign hold_free = !hold_q || (row_q == ROW_LAST);
	assign adv2 = v_s2 && hold_free;
	assign adv1 = v_s1 && (!v_s2 || adv2);
	assign pop  = head.valid && (!v_s1 || adv1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (!v_s1 || adv1)
				v_s1 <= head.valid;
			if (!v_s2 || adv2)
				v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			cbcc_s1 <= mul30(head.data.cb, head.data.cc);
			cbsc_s1 <= mul30(head.data.cb, head.data.sc);
			sasb_s1 <= mul30(head.data.sa, head.data.sb);
			casc_s1 <= mul30(head.data.ca, head.data.sc);
			cacc_s1 <= mul30(head.data.ca, head.data.cc);
			sacb_s1 <= mul30(head.data.sa, head.data.cb);
			casb_s1 <= mul30(head.data.ca, head.data.sb);
			sasc_s1 <= mul30(head.data.sa, head.data.sc);
			sacc_s1 <= mul30(head.data.sa, head.data.cc);
			cacb_s1 <= mul30(head.data.ca, head.data.cb);
			sb_s1   <= head.data.sb;
			sc_s1   <= head.data.sc;
			cc_s1   <= head.data.cc;
			tx_s1   <= head.data.tx;
			ty_s1   <= head.data.ty;
			tz_s1   <= head.data.tz;
			scl_s1  <= head.data.scale;
		end
		if (adv1) begin
			ssc_s2  <= mul30(sasb_s1, cc_s1);
			sss_s2  <= mul30(sasb_s1, sc_s1);
			csc_s2  <= mul30(casb_s1, cc_s1);
			css_s2  <= mul30(casb_s1, sc_s1);
			cbcc_s2 <= cbcc_s1;
			cbsc_s2 <= cbsc_s1;
			casc_s2 <= casc_s1;
			cacc_s2 <= cacc_s1;
			sacb_s2 <= sacb_s1;
			sasc_s2 <= sasc_s1;
			sacc_s2 <= sacc_s1;
			cacb_s2 <= cacb_s1;
			sb_s2   <= sb_s1;
			tx_s2   <= tx_s1;
			ty_s2   <= ty_s1;
			tz_s2   <= tz_s1;
			scl_s2  <= scl_s1;
		end
	end

	always_comb begin
		rn[0][0] = 34'(cbcc_s2);
		rn[0][1] = -34'(cbsc_s2);
		rn[0][2] = 34'(sb_s2);
		rn[1][0] = 34'(ssc_s2) + 34'(casc_s2);
		rn[1][1] = 34'(cacc_s2) - 34'(sss_s2);
		rn[1][2] = -34'(sacb_s2);
		rn[2][0] = 34'(sasc_s2) - 34'(csc_s2);
		rn[2][1] = 34'(css_s2) + 34'(sacc_s2);
		rn[2][2] = 34'(cacb_s2);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_q <= 1'b0;
			row_q  <= '0;
		end else if (adv2) begin
			hold_q <= 1'b1;
			row_q  <= '0;
		end else if (hold_q) begin
			row_q <= row_q + 1'b1;
			if (row_q == ROW_LAST)
				hold_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv2) begin
			rm_q  <= rn;
			tr_q  <= '{tx_s2, ty_s2, tz_s2};
			scl_q <= scl_s2;
		end
	end

	// Row scaling: three multipliers, rounding and saturation.
	logic signed [65:0] prod [0:2];
	logic signed [35:0] rsh  [0:2];
	logic [31:0]        sat  [0:2];
	logic [1:0]         ri;

	always_comb begin
		ri = (row_q == ROW_LAST) ? 2'd0 : row_q;
		for (int j = 0; j < 3; j++) begin
			prod[j] = rm_q[ri][j] * scl_q + 66'sd536870912;
			rsh[j]  = 36'(prod[j] >>> 30);
			if (rsh[j] > 36'sd2147483647)
				sat[j] = 32'h7fff_ffff;
			else if (rsh[j] < -36'sd2147483648)
				sat[j] = 32'h8000_0000;
			else
				sat[j] = 32'(rsh[j]);
		end
	end

	logic        ov_q;
	logic [1:0]  oi_q;
	logic [31:0] oe_q [0:3];
	logic        ol_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			ov_q <= 1'b0;
		else
			ov_q <= hold_q;
	end

	always_ff @(posedge clk) begin
		oi_q <= row_q;
		ol_q <= (row_q == ROW_LAST);
		if (row_q == ROW_LAST) begin
			oe_q <= '{32'd0, 32'd0, 32'd0, ONE};
		end else begin
			oe_q <= '{sat[0], sat[1], sat[2], tr_q[ri]};
		end
	end

	assign row_valid = ov_q;
	assign row_index = oi_q;
	assign elem_c0   = oe_q[0];
	assign elem_c1   = oe_q[1];
	assign elem_c2   = oe_q[2];
	assign elem_c3   = oe_q[3];
	assign last_row  = ol_q;

endmodule

`default_nettype wire

### hdl/model_transform_matrix_unit.sv
`default_nettype none
// ---------------------------------------------------------------------------
// Model transform matrix unit
// Builds M = T * Rx * Ry * Rz * S in Q16.16 and sends it as four row beats.
// ---------------------------------------------------------------------------
//
//  Channel   Handshake               Payload
//  -------   ---------------------   --------------------------------------
//  command   start high, busy low    trans_x/y/z, angle_x/y/z, uniform_scale
//  result    row_valid, one cycle    row_index, elem_c0..elem_c3, last_row
//
// Each transform yields four row beats on consecutive cycles; the single
// result port and the row scaler behind it bound the sustained rate, though
// commands are taken while earlier transforms are still in flight. A command
// reaches the first row via the CORDIC stages, the queue and the back end.
// Reset is asynchronous and clears all control state; no clearing pass.
// The receiver cannot stall. busy rises only when the queue between the
// CORDIC front end and the matrix back end could otherwise overflow.
//
// The front end reduces each angle to a quarter turn, then runs the three
// angles side by side through a CORDIC pipeline of one step per stage. Its
// output is written into a short queue. The back end pops one transform,
// forms the nine rotation terms over two multiply stages, holds the matrix
// and scales one row per cycle, rounding and saturating each element.
// A credit counter tracks every beat accepted but not yet popped, so the
// front pipeline never needs to stall.
// ---------------------------------------------------------------------------
module model_transform_matrix_unit #(
	parameter int CORDIC_STEPS = 16,
	parameter int FRAC_BITS    = 16
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	input  wire logic [31:0] trans_x,
	input  wire logic [31:0] trans_y,
	input  wire logic [31:0] trans_z,
	input  wire logic [15:0] angle_x,
	input  wire logic [15:0] angle_y,
	input  wire logic [15:0] angle_z,
	input  wire logic [31:0] uniform_scale,
	output logic             row_valid,
	output logic [1:0]       row_index,
	output logic [31:0]      elem_c0,
	output logic [31:0]      elem_c1,
	output logic [31:0]      elem_c2,
	output logic [31:0]      elem_c3,
	output logic             last_row
);
	import mtm_pkg::*;

	logic   accept;
	logic   push;
	logic   pop;
	entry_t push_data;
	head_t  head;

	// Beats inside the front end or the queue.
	logic [QAW:0] credit_q;

	assign accept = start && !busy;
	assign busy   = (credit_q == (QAW+1)'(QDEPTH));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			credit_q <= '0;
		else if (accept && !pop)
			credit_q <= credit_q + 1'b1;
		else if (pop && !accept)
			credit_q <= credit_q - 1'b1;
	end

	mtm_front #(
		.CORDIC_STEPS(CORDIC_STEPS)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (accept),
		.trans_x      (trans_x),
		.trans_y      (trans_y),
		.trans_z      (trans_z),
		.angle_x      (angle_x),
		.angle_y      (angle_y),
		.angle_z      (angle_z),
		.uniform_scale(uniform_scale),
		.push         (push),
		.push_data    (push_data)
	);

	mtm_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_data(push_data),
		.pop      (pop),
		.head     (head)
	);

	mtm_back #(
		.FRAC_BITS(FRAC_BITS)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.head     (head),
		.pop      (pop),
		.row_valid(row_valid),
		.row_index(row_index),
		.elem_c0  (elem_c0),
		.elem_c1  (elem_c1),
		.elem_c2  (elem_c2),
		.elem_c3  (elem_c3),
		.last_row (last_row)
	);

endmodule

`default_nettype wire
